// ===== rtl/fcw_pkg.sv =====
// fcw_pkg: shared widths, table entry type and orientation codes for the
// fundamental cycle walker; no dependencies
`default_nettype none

package fcw_pkg;

   localparam int NODE_W      = 5;
   localparam int DEPTH_W     = 6;
   localparam int EDGE_W      = 10;
   localparam int ORIENT_W    = 2;
   localparam int CNT_W       = 6;
   localparam int MAX_RESULTS = 63;

   localparam logic signed [DEPTH_W-1:0]  DEPTH_NONE = -6'sd1;

   localparam logic signed [ORIENT_W-1:0] ORIENT_POS  = 2'sb01;
   localparam logic signed [ORIENT_W-1:0] ORIENT_NEG  = 2'sb11;
   localparam logic signed [ORIENT_W-1:0] ORIENT_ZERO = 2'sb00;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0]         parent;
      logic signed [DEPTH_W-1:0] depth;
      logic [EDGE_W-1:0]         edge_id;
   } tbl_entry_type;

   // sign of (a - b) as a two-bit code
   function automatic logic signed [ORIENT_W-1:0] sign_code(
      input logic [NODE_W-1:0] a,
      input logic [NODE_W-1:0] b
   );
      logic signed [ORIENT_W-1:0] res;
      if (a > b) begin
         res = ORIENT_POS;
      end else if (a < b) begin
         res = ORIENT_NEG;
      end else begin
         res = ORIENT_ZERO;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fcw_if.sv =====
// fcw_if: request and response channel interfaces (valid/ready plus payload)
// depends on fcw_pkg for field widths
`default_nettype none

interface fcw_req_if import fcw_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [NODE_W-1:0]         node;
   logic [NODE_W-1:0]         parent_node;
   logic signed [DEPTH_W-1:0] node_depth;
   logic [EDGE_W-1:0]         tree_edge;
   logic [EDGE_W-1:0]         nontree_edge;
   logic [NODE_W-1:0]         end_a;
   logic [NODE_W-1:0]         end_b;
   logic                      first_positive;

   modport source (
      output valid, op, node, parent_node, node_depth, tree_edge,
             nontree_edge, end_a, end_b, first_positive,
      input  ready
   );
   modport sink (
      input  valid, op, node, parent_node, node_depth, tree_edge,
             nontree_edge, end_a, end_b, first_positive,
      output ready
   );
endinterface

interface fcw_rsp_if import fcw_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [EDGE_W-1:0]          row_edge;
   logic [EDGE_W-1:0]          cycle_id;
   logic signed [ORIENT_W-1:0] orient;
   logic                       last;

   modport source (
      output valid, row_edge, cycle_id, orient, last,
      input  ready
   );
   modport sink (
      input  valid, row_edge, cycle_id, orient, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/fcw_edge_mod.sv =====
// fcw_edge_mod: reduction of an edge id modulo EDGES by reciprocal
// multiplication, with the operand and then the quotient registered; depends on fcw_pkg
`default_nettype none

module fcw_edge_mod import fcw_pkg::*; #(
   parameter int EDGES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [EDGE_W-1:0] value,
   output logic                   done,
   output logic [EDGE_W-1:0]      result
);

   // floor(x * RECIP / 2^SHIFT) equals floor(x / EDGES) for every EDGE_W-bit x
   localparam int SHIFT   = EDGE_W + $clog2(EDGES);
   localparam int RECIP   = ((1 << SHIFT) + EDGES - 1) / EDGES;
   localparam int RECIP_W = EDGE_W + 2;
   localparam int PROD_W  = EDGE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
   localparam logic [EDGE_W-1:0]  EDGES_LO = EDGE_W'(EDGES);

   logic                  busy_ff;
   logic                  quot_vld_ff;
   logic [EDGE_W-1:0]     val_ff;
   logic [EDGE_W-1:0]     quot_ff;
   logic [PROD_W-1:0]     prod;
   logic [EDGE_W-1:0]     quot_in;
   logic [EDGE_W-1:0]     back;

   always_comb begin
      prod    = PROD_W'(val_ff) * PROD_W'(RECIP_C);
      quot_in = EDGE_W'(prod >> SHIFT);
      // quotient times EDGES never exceeds the value, so the low bits suffice
      back    = quot_ff * EDGES_LO;
   end

   assign done   = quot_vld_ff;
   assign result = val_ff - back;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         quot_vld_ff <= 1'b0;
      end else begin
         busy_ff     <= start;
         quot_vld_ff <= busy_ff;
         if (start) begin
            val_ff <= value;
         end
         if (busy_ff) begin
            quot_ff <= quot_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fundamental_cycle_walker_unit.sv =====
// fundamental_cycle_walker_unit: spanning-tree table and fundamental cycle walk
// depends on fcw_pkg, fcw_req_if / fcw_rsp_if and fcw_edge_mod
//
//   channel   dir   handshake     transaction
//   req_if    in    valid/ready   load one node entry, or query one non-tree edge
//   rsp_if    out   valid/ready   one cycle entry (row_edge, cycle_id, orient, last)
//
// a load reduces the edge id, writes the table entry once the reduction is done and
// then returns to idle, ready again
// a query runs through reduction, two table reads, the self entry, then up to 62 tree
// steps, with one memory read for each step after the first;
// an endpoint off the tree ends it after the second table read
// the table is one memory with a single registered read port
// reset clears control and the output valid flag; table contents stay undefined
// a full output register that is not taken holds the walk in place
`default_nettype none

module fundamental_cycle_walker_unit import fcw_pkg::*; #(
   parameter int NODES = 32,
   parameter int EDGES = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   fcw_req_if.sink   req_if,
   fcw_rsp_if.source rsp_if
);

   localparam int TBL_DEPTH = (NODES < 32) ? NODES : 32;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RD_V,
      ST_RD_W,
      ST_SELF,
      ST_WALK
   } state_type;

   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return 32'(n) < NODES;
   endfunction

   state_type                 state_ff;
   logic                      op_ff;
   logic [NODE_W-1:0]         node_ff;
   logic [NODE_W-1:0]         parent_ff;
   logic signed [DEPTH_W-1:0] depth_ff;
   logic [NODE_W-1:0]         v_ff;
   logic [NODE_W-1:0]         w_ff;
   logic [EDGE_W-1:0]         id_ff;
   tbl_entry_type             ent_v_ff;
   tbl_entry_type             ent_w_ff;
   logic                      pend_v_ff;
   logic                      pend_w_ff;
   logic [CNT_W-1:0]          count_ff;

   logic                       rsp_valid_ff;
   logic [EDGE_W-1:0]          rsp_row_ff;
   logic [EDGE_W-1:0]          rsp_id_ff;
   logic signed [ORIENT_W-1:0] rsp_orient_ff;
   logic                       rsp_last_ff;

   tbl_entry_type             tbl_mem [TBL_DEPTH];
   tbl_entry_type             rd_data_ff;
   logic                      rd_en;
   logic [TBL_AW-1:0]         rd_addr;
   logic                      wr_en;
   logic [TBL_AW-1:0]         wr_addr;
   tbl_entry_type             wr_data;

   logic                      req_take;
   logic                      red_done;
   logic [EDGE_W-1:0]         red_result;
   logic                      slot_free;
   logic                      rsp_emit;
   logic                      query_ok;

   tbl_entry_type              eff_v;
   tbl_entry_type              eff_w;
   logic                       step_v;
   tbl_entry_type              cur_ent;
   logic [NODE_W-1:0]          other_node;
   logic [NODE_W-1:0]          par;
   logic signed [ORIENT_W-1:0] step_orient;
   logic [CNT_W-1:0]           next_count;
   logic                       walk_last;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign rsp_emit     = slot_free && ((state_ff == ST_SELF) || (state_ff == ST_WALK));

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.row_edge = rsp_row_ff;
   assign rsp_if.cycle_id = rsp_id_ff;
   assign rsp_if.orient   = rsp_orient_ff;
   assign rsp_if.last     = rsp_last_ff;

   fcw_edge_mod #(
      .EDGES (EDGES)
   ) u_edge_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .value  ((req_if.op == OP_QUERY) ? req_if.nontree_edge : req_if.tree_edge),
      .done   (red_done),
      .result (red_result)
   );

   assign query_ok = node_ok(v_ff) && node_ok(w_ff);

   // walk step: the side read last cycle comes straight from the memory output
   always_comb begin
      eff_v       = pend_v_ff ? rd_data_ff : ent_v_ff;
      eff_w       = pend_w_ff ? rd_data_ff : ent_w_ff;
      step_v      = eff_v.depth >= eff_w.depth;
      cur_ent     = step_v ? eff_v : eff_w;
      other_node  = step_v ? w_ff : v_ff;
      par         = cur_ent.parent;
      step_orient = step_v ? sign_code(v_ff, par) : sign_code(par, w_ff);
      next_count  = count_ff + 1'b1;
      walk_last   = (par == other_node) || !node_ok(par) ||
                    (next_count == CNT_W'(MAX_RESULTS));
   end

   // table port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = v_ff[TBL_AW-1:0];
      wr_en   = 1'b0;
      wr_addr = node_ff[TBL_AW-1:0];
      wr_data = '{parent: parent_ff, depth: depth_ff, edge_id: red_result};
      unique case (state_ff)
         ST_REDUCE: begin
            if (red_done) begin
               if (op_ff == OP_LOAD) begin
                  wr_en = node_ok(node_ff);
               end else begin
                  rd_en = query_ok;
               end
            end
         end
         ST_RD_V: begin
            rd_en   = 1'b1;
            rd_addr = w_ff[TBL_AW-1:0];
         end
         ST_WALK: begin
            rd_en   = slot_free && !walk_last;
            rd_addr = par[TBL_AW-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         pend_w_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (rsp_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_ff     <= req_if.op;
                  node_ff   <= req_if.node;
                  parent_ff <= req_if.parent_node;
                  depth_ff  <= req_if.node_depth;
                  v_ff      <= req_if.first_positive ? req_if.end_a : req_if.end_b;
                  w_ff      <= req_if.first_positive ? req_if.end_b : req_if.end_a;
                  state_ff  <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (red_done) begin
                  id_ff <= red_result;
                  if ((op_ff == OP_QUERY) && query_ok) begin
                     state_ff <= ST_RD_V;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_RD_V: begin
               ent_v_ff <= rd_data_ff;
               state_ff <= ST_RD_W;
            end
            ST_RD_W: begin
               ent_w_ff  <= rd_data_ff;
               pend_v_ff <= 1'b0;
               pend_w_ff <= 1'b0;
               if ((ent_v_ff.depth == DEPTH_NONE) || (rd_data_ff.depth == DEPTH_NONE)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_SELF;
               end
            end
            ST_SELF: begin
               if (slot_free) begin
                  rsp_row_ff    <= id_ff;
                  rsp_id_ff     <= id_ff;
                  rsp_orient_ff <= ORIENT_NEG;
                  rsp_last_ff   <= (v_ff == w_ff);
                  count_ff      <= CNT_W'(1);
                  state_ff      <= (v_ff == w_ff) ? ST_IDLE : ST_WALK;
               end
            end
            ST_WALK: begin
               ent_v_ff  <= eff_v;
               ent_w_ff  <= eff_w;
               pend_v_ff <= slot_free && step_v && !walk_last;
               pend_w_ff <= slot_free && !step_v && !walk_last;
               if (slot_free) begin
                  rsp_row_ff    <= cur_ent.edge_id;
                  rsp_id_ff     <= id_ff;
                  rsp_orient_ff <= step_orient;
                  rsp_last_ff   <= walk_last;
                  count_ff      <= next_count;
                  if (step_v) begin
                     v_ff <= par;
                  end else begin
                     w_ff <= par;
                  end
                  if (walk_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== test/fundamental_cycle_walker_unit_tb.sv =====
// testbench for fundamental_cycle_walker_unit: loads spanning-tree tables, queries
// non-tree edges and checks every cycle entry against a predictor of its own
// depends on fcw_pkg, fcw_req_if / fcw_rsp_if and the block itself
`timescale 1ns / 1ps

module fundamental_cycle_walker_unit_tb import fcw_pkg::*; ();

   typedef struct {
      logic                      op;
      logic [NODE_W-1:0]         node;
      logic [NODE_W-1:0]         parent_node;
      logic signed [DEPTH_W-1:0] node_depth;
      logic [EDGE_W-1:0]         tree_edge;
      logic [EDGE_W-1:0]         nontree_edge;
      logic [NODE_W-1:0]         end_a;
      logic [NODE_W-1:0]         end_b;
      logic                      first_positive;
   } walk_req_type;

   typedef struct {
      logic [EDGE_W-1:0]          row_edge;
      logic [EDGE_W-1:0]          cycle_id;
      logic signed [ORIENT_W-1:0] orient;
      logic                       last;
   } cycle_entry_type;

   class cycle_walk_tracker;
      logic [NODE_W-1:0]         parent_tbl [1 << NODE_W];
      logic signed [DEPTH_W-1:0] depth_tbl [1 << NODE_W];
      logic [EDGE_W-1:0]         edge_tbl [1 << NODE_W];
      cycle_entry_type           pending_entries[$];
      int                        error_count;

      function logic signed [ORIENT_W-1:0] step_sign(logic [NODE_W-1:0] x,
                                                     logic [NODE_W-1:0] y);
         if (x > y) return ORIENT_POS;
         if (x < y) return ORIENT_NEG;
         return ORIENT_ZERO;
      endfunction

      function void push_entry(logic [EDGE_W-1:0] row, logic [EDGE_W-1:0] id,
                               logic signed [ORIENT_W-1:0] sgn);
         cycle_entry_type e;
         e.row_edge = row;
         e.cycle_id = id;
         e.orient   = sgn;
         e.last     = 1'b0;
         pending_entries.push_back(e);
      endfunction

      // table write on a load, cycle walk on a query
      function void absorb_request(walk_req_type it);
         logic [NODE_W-1:0] v;
         logic [NODE_W-1:0] w;
         logic [NODE_W-1:0] p;
         int                count;
         if (it.op == OP_LOAD) begin
            parent_tbl[it.node] = it.parent_node;
            depth_tbl[it.node]  = it.node_depth;
            edge_tbl[it.node]   = it.tree_edge;
            return;
         end
         v = it.first_positive ? it.end_a : it.end_b;
         w = it.first_positive ? it.end_b : it.end_a;
         if (depth_tbl[v] == DEPTH_NONE || depth_tbl[w] == DEPTH_NONE) return;
         push_entry(it.nontree_edge, it.nontree_edge, ORIENT_NEG);
         count = 1;
         // deeper endpoint climbs first, v on equal depth
         while (v != w && count < MAX_RESULTS) begin
            if (depth_tbl[v] >= depth_tbl[w]) begin
               p = parent_tbl[v];
               push_entry(edge_tbl[v], it.nontree_edge, step_sign(v, p));
               v = p;
            end else begin
               p = parent_tbl[w];
               push_entry(edge_tbl[w], it.nontree_edge, step_sign(p, w));
               w = p;
            end
            count++;
         end
         pending_entries[pending_entries.size() - 1].last = 1'b1;
      endfunction

      function int outstanding();
         return pending_entries.size();
      endfunction

      function void flag(string what, int want, int got);
         error_count++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
      endfunction

      function void check_entry(cycle_entry_type got);
         cycle_entry_type want;
         if (pending_entries.size() == 0) begin
            error_count++;
            $display("%0t unexpected transaction: expected none actual row_edge %0d cycle_id %0d",
                     $time, got.row_edge, got.cycle_id);
            return;
         end
         want = pending_entries.pop_front();
         if (got.row_edge !== want.row_edge)
            flag("row_edge", int'(want.row_edge), int'(got.row_edge));
         if (got.cycle_id !== want.cycle_id)
            flag("cycle_id", int'(want.cycle_id), int'(got.cycle_id));
         if (got.orient !== want.orient)
            flag("orient", int'(want.orient), int'(got.orient));
         if (got.last !== want.last)
            flag("last", int'(want.last), int'(got.last));
      endfunction
   endclass

   localparam int NUM_NODES    = 1 << NODE_W;
   localparam int TOTAL_ITEMS  = 270;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 600000;

   logic clock;
   logic reset;

   fcw_req_if req_bus ();
   fcw_rsp_if rsp_bus ();

   fundamental_cycle_walker_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   cycle_walk_tracker tracker = new();

   int cycle_count  = 0;
   int items_sent   = 0;
   int stall_left   = 0;
   bit send_burst   = 0;
   bit rx_burst     = 0;
   bit hold_request = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL fundamental_cycle_walker_unit");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      cycle_entry_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.row_edge = rsp_bus.row_edge;
         got.cycle_id = rsp_bus.cycle_id;
         got.orient   = rsp_bus.orient;
         got.last     = rsp_bus.last;
         tracker.check_entry(got);
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         stall_left = rx_burst ? 0 : $urandom_range(0, 5);
      end
   end

   // receiver: random stalls per transaction plus one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic walk_req_type random_req();
      walk_req_type it;
      int           d;
      d = $urandom_range(0, 32) - 1;
      it.op             = 1'($urandom_range(0, 1));
      it.node           = NODE_W'($urandom_range(0, NUM_NODES - 1));
      it.parent_node    = NODE_W'($urandom_range(0, NUM_NODES - 1));
      it.node_depth     = d[DEPTH_W-1:0];
      it.tree_edge      = EDGE_W'($urandom_range(0, 1023));
      it.nontree_edge   = EDGE_W'($urandom_range(0, 1023));
      it.end_a          = NODE_W'($urandom_range(0, NUM_NODES - 1));
      it.end_b          = NODE_W'($urandom_range(0, NUM_NODES - 1));
      it.first_positive = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // entered and left at a falling edge
   task automatic offer(input walk_req_type it);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.op             <= it.op;
      req_bus.node           <= it.node;
      req_bus.parent_node    <= it.parent_node;
      req_bus.node_depth     <= it.node_depth;
      req_bus.tree_edge      <= it.tree_edge;
      req_bus.nontree_edge   <= it.nontree_edge;
      req_bus.end_a          <= it.end_a;
      req_bus.end_b          <= it.end_b;
      req_bus.first_positive <= it.first_positive;
      do @(posedge clock); while (!req_bus.ready);
      tracker.absorb_request(it);
      items_sent++;
      if (items_sent == 120) hold_request = 1;
      if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
      @(negedge clock);
   endtask

   task automatic load_node(input int nd, input int par, input int dep, input int eid);
      walk_req_type it;
      it = random_req();
      it.op          = OP_LOAD;
      it.node        = NODE_W'(nd);
      it.parent_node = NODE_W'(par);
      it.node_depth  = dep[DEPTH_W-1:0];
      it.tree_edge   = EDGE_W'(eid);
      offer(it);
   endtask

   task automatic query_cycle(input int id, input int a, input int b, input bit pos);
      walk_req_type it;
      it = random_req();
      it.op             = OP_QUERY;
      it.nontree_edge   = EDGE_W'(id);
      it.end_a          = NODE_W'(a);
      it.end_b          = NODE_W'(b);
      it.first_positive = pos;
      offer(it);
   endtask

   task automatic drain_pause();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (tracker.outstanding() != 0);
   endtask

   // random forest over all nodes, biased toward long chains
   task automatic build_forest();
      int           order [NUM_NODES];
      int           true_depth [NUM_NODES];
      int           j;
      int           k;
      int           tmp;
      walk_req_type it;
      for (k = 0; k < NUM_NODES; k++) order[k] = k;
      for (k = NUM_NODES - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < NUM_NODES; k++) begin
         it = random_req();
         it.op   = OP_LOAD;
         it.node = NODE_W'(order[k]);
         if (k == 0 || $urandom_range(0, 7) == 0) begin
            true_depth[order[k]] = 0;
            it.parent_node = NODE_W'($urandom_range(0, 1) ? order[k] :
                                     $urandom_range(0, NUM_NODES - 1));
         end else begin
            j = $urandom_range(0, 1) ? k - 1 : $urandom_range(0, k - 1);
            it.parent_node = NODE_W'(order[j]);
            true_depth[order[k]] = true_depth[order[j]] + 1;
         end
         tmp = true_depth[order[k]];
         it.node_depth = ($urandom_range(0, 15) == 0) ? DEPTH_NONE : tmp[DEPTH_W-1:0];
         offer(it);
      end
   endtask

   initial begin
      walk_req_type it;
      int           pick;
      bit           paused_once;
      paused_once            = 0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.op             = OP_LOAD;
      req_bus.node           = '0;
      req_bus.parent_node    = '0;
      req_bus.node_depth     = '0;
      req_bus.tree_edge      = '0;
      req_bus.nontree_edge   = '0;
      req_bus.end_a          = '0;
      req_bus.end_b          = '0;
      req_bus.first_positive = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // small hand-built tree: chain 3-1-0, leaf 2, deep node 31 with a bogus depth,
      // self-looped node 30 and off-tree node 29
      load_node(0, 0, 0, 0);
      load_node(1, 0, 1, 1023);
      load_node(2, 0, 1, 341);
      load_node(3, 1, 2, 682);
      load_node(31, 3, 31, 512);
      load_node(30, 30, 3, 777);
      load_node(29, 31, -1, 100);
      query_cycle(0, 3, 2, 1'b1);
      query_cycle(1023, 3, 2, 1'b0);
      query_cycle(5, 1, 1, 1'b1);
      query_cycle(6, 29, 0, 1'b1);
      query_cycle(7, 0, 29, 1'b0);
      query_cycle(1023, 31, 2, 1'b0);
      query_cycle(8, 30, 0, 1'b1);   // walk never meets, stops at the cap
      query_cycle(9, 0, 30, 1'b1);
      query_cycle(10, 2, 3, 1'b1);
      query_cycle(11, 31, 0, 1'b1);
      drain_pause();

      // every entry is written here, so any later query reads defined entries
      build_forest();
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            build_forest();
         end else if (pick < 15) begin
            it = random_req();
            it.op = OP_LOAD;
            offer(it);
         end else begin
            it = random_req();
            it.op = OP_QUERY;
            if ($urandom_range(0, 9) == 0) it.end_b = it.end_a;
            offer(it);
         end
         if (!paused_once && items_sent >= 200) begin
            paused_once = 1;
            drain_pause();
         end
      end
      req_bus.valid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("PASS fundamental_cycle_walker_unit");
      end else begin
         $display("FAIL fundamental_cycle_walker_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fcw_pkg.sv
rtl/fcw_if.sv
rtl/fcw_edge_mod.sv
rtl/fundamental_cycle_walker_unit.sv
test/fundamental_cycle_walker_unit_tb.sv
